@@ src/assert_macros.svh @@
// Assertion macros for the scheduler RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// prop must hold at every rising edge outside reset
`define MLFQ_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");
// cond must never be true at a rising edge outside reset
`define MLFQ_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");
`else
`define MLFQ_ASSERT(lbl, clk, rst_n, prop)
`define MLFQ_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

@@ src/mlfq_pkg.sv @@
// Shared types and constants of the multilevel feedback queue scheduler.
// No dependencies; every scheduler module imports this package.
package mlfq_pkg;

	localparam int MAX_PROCS_DEF  = 16;
	localparam int MAX_LEVELS_DEF = 4;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BOOST_PERIOD  = 2'd2;

	localparam logic [4:0]  RST_PROCESS_COUNT = 5'd16;
	localparam logic [2:0]  RST_LEVEL_COUNT   = 3'd4;
	localparam logic [15:0] RST_BOOST_PERIOD  = 16'd8;

	// input opcodes
	localparam logic OP_START = 1'b0;
	localparam logic OP_SLICE = 1'b1;

	// result event kinds
	localparam logic [2:0] EV_DEMOTED = 3'd0;
	localparam logic [2:0] EV_STAYED  = 3'd1;
	localparam logic [2:0] EV_EXITED  = 3'd2;
	localparam logic [2:0] EV_BOOSTED = 3'd3;
	localparam logic [2:0] EV_IDLE    = 3'd4;

	// effective configuration, already saturated into range
	typedef struct packed {
		logic [4:0]  n_procs;
		logic [2:0]  n_levels;
		logic [15:0] period;
	} cfg_t;

	typedef struct packed {
		logic [2:0] event_kind;
		logic [4:0] process_id;
		logic [2:0] queue_label;
		logic       last;
	} rec_t;

endpackage

@@ src/mlfq_cfg.sv @@
// Configuration registers of the scheduler and their saturation into range.
// Depends on mlfq_pkg.
module mlfq_cfg #(
	parameter int MAX_PROCS  = mlfq_pkg::MAX_PROCS_DEF,
	parameter int MAX_LEVELS = mlfq_pkg::MAX_LEVELS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mlfq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mlfq_pkg::CFG_DATA_W-1:0]  cfg_data,
	output mlfq_pkg::cfg_t                   cfg_eff
);
	import mlfq_pkg::*;

	logic [4:0]  process_count_q;
	logic [2:0]  level_count_q;
	logic [15:0] boost_period_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			process_count_q <= RST_PROCESS_COUNT;
			level_count_q   <= RST_LEVEL_COUNT;
			boost_period_q  <= RST_BOOST_PERIOD;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PROCESS_COUNT: process_count_q <= cfg_data[4:0];
				CFG_LEVEL_COUNT:   level_count_q   <= cfg_data[2:0];
				CFG_BOOST_PERIOD:  boost_period_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (int'(process_count_q) > MAX_PROCS) begin
			cfg_eff.n_procs = 5'(MAX_PROCS);
		end else begin
			cfg_eff.n_procs = process_count_q;
		end
		if (level_count_q == 3'd0) begin
			cfg_eff.n_levels = 3'd1;
		end else if (int'(level_count_q) > MAX_LEVELS) begin
			cfg_eff.n_levels = 3'(MAX_LEVELS);
		end else begin
			cfg_eff.n_levels = level_count_q;
		end
		cfg_eff.period = (boost_period_q == 16'd0) ? 16'd1 : boost_period_q;
	end

endmodule

@@ src/mlfq_out_reg.sv @@
// Output register of the scheduler: holds one result until the sink takes it.
// Depends on mlfq_pkg.
module mlfq_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           emit,
	input  mlfq_pkg::rec_t rec_in,
	output logic           slot_free,
	output logic           out_valid,
	input  logic           out_ready,
	output mlfq_pkg::rec_t rec_q
);
	import mlfq_pkg::*;

	logic valid_q;

	// the slot frees in the same cycle its transaction completes
	assign slot_free = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rec_q <= rec_in;
		end
	end

endmodule

@@ src/mlfq_ctrl.sv @@
// Queue controller: link memory, queue heads and tails, slice and boost sequencer.
// Depends on mlfq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mlfq_ctrl #(
	parameter int MAX_PROCS  = mlfq_pkg::MAX_PROCS_DEF,
	parameter int MAX_LEVELS = mlfq_pkg::MAX_LEVELS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mlfq_pkg::cfg_t cfg_eff,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           opcode,
	input  logic           used_full_quantum,
	input  logic           finishes,
	input  logic           slot_free,
	output logic           emit,
	output mlfq_pkg::rec_t rec
);
	import mlfq_pkg::*;

	localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int CW = $clog2(MAX_PROCS + 1);
	localparam logic [MAX_LEVELS-1:0] LOW_MASK = ~MAX_LEVELS'(1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOAD  = 3'd1;
	localparam logic [2:0] ST_FIND  = 3'd2;
	localparam logic [2:0] ST_POP   = 3'd3;
	localparam logic [2:0] ST_PUSH  = 3'd4;
	localparam logic [2:0] ST_BFIND = 3'd5;
	localparam logic [2:0] ST_BMOVE = 3'd6;

	logic [2:0]            state_q;
	logic [MAX_LEVELS-1:0] nonempty_q;
	logic [15:0]           slice_q;
	logic [CW-1:0]         live_q;
	logic [PW-1:0]         ld_cnt_q;
	logic [LW-1:0]         lvl_q;
	logic [LW-1:0]         dst_q;
	logic [PW-1:0]         pid_q;
	logic                  full_q;
	logic                  fin_q;
	logic [PW-1:0]         head_q [MAX_LEVELS];
	logic [PW-1:0]         tail_q [MAX_LEVELS];

	// next-process links, one entry per process
	logic [PW-1:0]         link_mem [MAX_PROCS];
	logic [PW-1:0]         rd_data_q;
	logic                  mem_we;
	logic [PW-1:0]         mem_wa;
	logic [PW-1:0]         mem_wd;
	logic                  mem_re;

	logic                  accept;
	logic [CW-1:0]         n_load;
	logic [3:0]            nlev4;
	logic [3:0]            lvl4;
	logic [3:0]            dst4;
	logic                  any_ne;
	logic [LW-1:0]         f_lvl;
	logic [LW-1:0]         b_lvl;
	logic [LW-1:0]         sel_lvl;
	logic [LW-1:0]         dst_calc;
	logic [2:0]            dst_label;
	logic [PW-1:0]         head_sel;
	logic [PW-1:0]         tail_sel;
	logic [PW-1:0]         tail_top;
	logic                  pop_last;
	logic [15:0]           slice_inc;
	logic                  boost_due;
	logic [MAX_LEVELS-1:0] push_ne;
	logic                  push_more;
	logic [MAX_LEVELS-1:0] bm_ne;
	logic                  bm_more;
	logic [4:0]            pid_out;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign n_load   = CW'(cfg_eff.n_procs);
	assign nlev4    = {1'b0, cfg_eff.n_levels};
	assign lvl4     = 4'(lvl_q);
	assign dst4     = 4'(dst_q);
	assign any_ne   = |nonempty_q;

	// lowest-numbered occupied level, and the same among the levels below the top
	always_comb begin
		f_lvl = '0;
		b_lvl = '0;
		for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
			if (nonempty_q[i]) begin
				f_lvl = LW'(i);
			end
		end
		for (int i = MAX_LEVELS - 1; i >= 1; i--) begin
			if (nonempty_q[i]) begin
				b_lvl = LW'(i);
			end
		end
	end

	always_comb begin
		case (state_q)
			ST_FIND:  sel_lvl = f_lvl;
			ST_BFIND: sel_lvl = b_lvl;
			ST_PUSH:  sel_lvl = dst_q;
			default:  sel_lvl = lvl_q;
		endcase
	end

	assign head_sel = head_q[sel_lvl];
	assign tail_sel = tail_q[sel_lvl];
	assign tail_top = tail_q[0];
	assign pop_last = (pid_q == tail_sel);

	// demotion saturates at the lowest level in use; labels count down from the top
	assign dst_calc  = ((lvl4 + 4'd1) < nlev4) ? LW'(lvl4 + 4'd1) : lvl_q;
	assign dst_label = (dst4 < nlev4) ? 3'(nlev4 - dst4) : 3'd1;

	assign slice_inc = slice_q + 16'd1;
	assign boost_due = (slice_inc >= cfg_eff.period);
	assign push_ne   = fin_q ? nonempty_q : (nonempty_q | (MAX_LEVELS'(1) << dst_q));
	assign push_more = boost_due && ((push_ne & LOW_MASK) != '0);
	assign bm_ne     = (pop_last ? (nonempty_q & ~(MAX_LEVELS'(1) << lvl_q)) : nonempty_q)
		| MAX_LEVELS'(1);
	assign bm_more   = ((bm_ne & LOW_MASK) != '0);
	assign pid_out   = 5'(7'(pid_q) + 7'd1);

	always_comb begin
		emit   = 1'b0;
		rec    = '0;
		mem_we = 1'b0;
		mem_wa = tail_top;
		mem_wd = pid_q;
		mem_re = 1'b0;
		case (state_q)
			ST_LOAD: begin
				if (ld_cnt_q != '0) begin
					mem_we = 1'b1;
					mem_wa = ld_cnt_q - PW'(1);
					mem_wd = ld_cnt_q;
				end
			end
			ST_FIND: begin
				if (any_ne) begin
					mem_re = 1'b1;
				end else if (slot_free) begin
					emit            = 1'b1;
					rec.event_kind  = EV_IDLE;
					rec.process_id  = '0;
					rec.queue_label = '0;
					rec.last        = 1'b1;
				end
			end
			ST_PUSH: begin
				if (slot_free) begin
					emit           = 1'b1;
					rec.process_id = pid_out;
					rec.last       = !push_more;
					if (fin_q) begin
						rec.event_kind  = EV_EXITED;
						rec.queue_label = '0;
					end else begin
						rec.event_kind  = full_q ? EV_DEMOTED : EV_STAYED;
						rec.queue_label = dst_label;
						if (nonempty_q[dst_q]) begin
							mem_we = 1'b1;
							mem_wa = tail_sel;
						end
					end
				end
			end
			ST_BFIND: begin
				mem_re = 1'b1;
			end
			ST_BMOVE: begin
				if (slot_free) begin
					emit            = 1'b1;
					rec.event_kind  = EV_BOOSTED;
					rec.process_id  = pid_out;
					rec.queue_label = cfg_eff.n_levels;
					rec.last        = !bm_more;
					if (nonempty_q[0]) begin
						mem_we = 1'b1;
						mem_wa = tail_top;
					end
				end
			end
			default: ;
		endcase
	end

	// reads and writes never fall in the same state, so no forwarding is needed
	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= link_mem[head_sel];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			nonempty_q <= '0;
			slice_q    <= '0;
			live_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (opcode == OP_START) begin
							nonempty_q <= '0;
							slice_q    <= '0;
							live_q     <= n_load;
							state_q    <= (n_load == '0) ? ST_IDLE : ST_LOAD;
						end else begin
							state_q <= ST_FIND;
						end
					end
				end
				ST_LOAD: begin
					nonempty_q[0] <= 1'b1;
					if (CW'(ld_cnt_q) == n_load - CW'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FIND: begin
					if (any_ne) begin
						state_q <= ST_POP;
					end else if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_POP: begin
					if (pop_last) begin
						nonempty_q[lvl_q] <= 1'b0;
					end
					if (fin_q && live_q != '0) begin
						live_q <= live_q - CW'(1);
					end
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (slot_free) begin
						nonempty_q <= push_ne;
						slice_q    <= boost_due ? 16'd0 : slice_inc;
						state_q    <= push_more ? ST_BFIND : ST_IDLE;
					end
				end
				ST_BFIND: begin
					state_q <= ST_BMOVE;
				end
				ST_BMOVE: begin
					if (slot_free) begin
						nonempty_q <= bm_ne;
						state_q    <= bm_more ? ST_BFIND : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ld_cnt_q <= '0;
					full_q   <= used_full_quantum;
					fin_q    <= finishes;
				end
			end
			ST_LOAD: begin
				if (ld_cnt_q == '0) begin
					head_q[0] <= '0;
				end
				tail_q[0] <= ld_cnt_q;
				ld_cnt_q  <= ld_cnt_q + PW'(1);
			end
			ST_FIND: begin
				lvl_q <= f_lvl;
				pid_q <= head_sel;
			end
			ST_POP: begin
				if (!pop_last) begin
					head_q[lvl_q] <= rd_data_q;
				end
				dst_q <= full_q ? dst_calc : lvl_q;
			end
			ST_PUSH: begin
				if (slot_free && !fin_q) begin
					if (!nonempty_q[dst_q]) begin
						head_q[dst_q] <= pid_q;
					end
					tail_q[dst_q] <= pid_q;
				end
			end
			ST_BFIND: begin
				lvl_q <= b_lvl;
				pid_q <= head_sel;
			end
			ST_BMOVE: begin
				if (slot_free) begin
					if (!pop_last) begin
						head_q[lvl_q] <= rd_data_q;
					end
					if (!nonempty_q[0]) begin
						head_q[0] <= pid_q;
					end
					tail_q[0] <= pid_q;
				end
			end
			default: ;
		endcase
	end

	`MLFQ_ASSERT(a_live_when_queued, clk, arst_n, (nonempty_q != '0) |-> (live_q != '0))
	`MLFQ_ASSERT(a_pop_follows_read, clk, arst_n, (state_q == ST_POP) |-> ($past(state_q) == ST_FIND))
	`MLFQ_ASSERT(a_boost_has_work, clk, arst_n, (state_q == ST_BFIND) |-> ((nonempty_q & LOW_MASK) != '0))
	`MLFQ_NEVER(a_emit_into_full, clk, arst_n, emit && !slot_free)

endmodule

@@ src/multilevel_feedback_queue_scheduler.sv @@
// Top level of the multilevel feedback queue scheduler.
// Depends on mlfq_pkg, mlfq_cfg, mlfq_ctrl and mlfq_out_reg.

// Processes wait in MAX_LEVELS linked-list queues whose next-process links live
// in a synchronous memory with a registered read port; queue heads and tails
// sit in small register files. A start transaction is accepted, then the load
// state links the loaded processes into the top queue in order. A slice
// transaction runs accept, locate the highest occupied queue and read the
// head's link, pop, then push and report; when a priority boost follows, each
// boosted process takes a link read, then a move and report, so the boost walk
// sets the worst case. A slice with no waiting process returns one idle result.
// Results leave through a one-entry output register, so the next transaction
// is taken while the last result still waits. No clearing pass follows reset:
// queue storage is only read where the occupancy bits say it was written.
module multilevel_feedback_queue_scheduler #(
	parameter int MAX_PROCS  = mlfq_pkg::MAX_PROCS_DEF,
	parameter int MAX_LEVELS = mlfq_pkg::MAX_LEVELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            opcode,
	input  logic                            used_full_quantum,
	input  logic                            finishes,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [2:0]                      event_kind,
	output logic [4:0]                      process_id,
	output logic [2:0]                      queue_label,
	output logic                            last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mlfq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mlfq_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mlfq_pkg::*;

	cfg_t cfg_eff;
	rec_t rec_new;
	rec_t rec_out;
	logic emit;
	logic slot_free;

	mlfq_cfg #(
		.MAX_PROCS  (MAX_PROCS),
		.MAX_LEVELS (MAX_LEVELS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_eff   (cfg_eff)
	);

	mlfq_ctrl #(
		.MAX_PROCS  (MAX_PROCS),
		.MAX_LEVELS (MAX_LEVELS)
	) u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_eff           (cfg_eff),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.opcode            (opcode),
		.used_full_quantum (used_full_quantum),
		.finishes          (finishes),
		.slot_free         (slot_free),
		.emit              (emit),
		.rec               (rec_new)
	);

	mlfq_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.rec_in    (rec_new),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rec_q     (rec_out)
	);

	assign event_kind  = rec_out.event_kind;
	assign process_id  = rec_out.process_id;
	assign queue_label = rec_out.queue_label;
	assign last        = rec_out.last;

endmodule

@@ bench/tb_multilevel_feedback_queue_scheduler.sv @@
// Self-checking bench for the multilevel feedback queue scheduler.
// Needs mlfq_pkg and the scheduler RTL; keeps its own copy of the queues to
// predict every record, then drives directed and random start, slice and register traffic.
module tb_multilevel_feedback_queue_scheduler;
	import mlfq_pkg::*;

	localparam int NPROC = MAX_PROCS_DEF;
	localparam int NLEV  = MAX_LEVELS_DEF;
	localparam int DRAIN_CYCLES = 64;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

	typedef struct packed {
		logic op;
		logic full;
		logic fin;
	} sched_req_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic opcode = OP_START;
	logic used_full_quantum = 1'b0;
	logic finishes = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] event_kind;
	logic [4:0] process_id;
	logic [2:0] queue_label;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_PROCESS_COUNT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	multilevel_feedback_queue_scheduler DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.used_full_quantum(used_full_quantum),
		.finishes(finishes),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_kind(event_kind),
		.process_id(process_id),
		.queue_label(queue_label),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// scheduler image: linked queues, occupancy, slice counter, registers
	logic [3:0]  proc_link [NPROC];
	logic [3:0]  queue_head [NLEV];
	logic [3:0]  queue_tail [NLEV];
	logic [NLEV-1:0] queue_busy = '0;
	logic [15:0] slice_tally = '0;
	logic [4:0]  cfg_procs = RST_PROCESS_COUNT;
	logic [2:0]  cfg_levels = RST_LEVEL_COUNT;
	logic [15:0] cfg_period = RST_BOOST_PERIOD;

	sched_req_t req_backlog[$];
	reg_write_t cfg_backlog[$];
	rec_t expected_recs[$];

	bit calm = 1'b0;
	int errors = 0;
	int n_starts = 0, n_slices = 0, n_results = 0, n_idle = 0, n_boosts = 0;
	int n_writes = 0, n_settings = 1;

	function automatic logic [2:0] levels_in_use();
		if (cfg_levels == 3'd0)
			return 3'd1;
		if (cfg_levels > NLEV)
			return 3'(NLEV);
		return cfg_levels;
	endfunction

	function automatic logic [2:0] label_for(int lvl);
		int n;
		n = levels_in_use();
		return (lvl < n) ? 3'(n - lvl) : 3'd1;
	endfunction

	task automatic enqueue(int lvl, logic [3:0] p);
		if (queue_busy[lvl])
			proc_link[queue_tail[lvl]] = p;
		else begin
			queue_head[lvl] = p;
			queue_busy[lvl] = 1'b1;
		end
		queue_tail[lvl] = p;
	endtask

	task automatic dequeue(int lvl, output logic [3:0] p);
		p = queue_head[lvl];
		if (p == queue_tail[lvl])
			queue_busy[lvl] = 1'b0;
		else
			queue_head[lvl] = proc_link[p];
	endtask

	// work out the records one accepted transaction causes
	task automatic schedule_item(sched_req_t r);
		rec_t recs[$];
		rec_t rec;
		logic [3:0] p;
		logic [15:0] period;
		int lvl, dst, n, i;
		if (r.op == OP_START) begin
			n = (cfg_procs > NPROC) ? NPROC : cfg_procs;
			queue_busy = '0;
			slice_tally = '0;
			for (i = 0; i < n; i++)
				enqueue(0, 4'(i));
			return;
		end
		lvl = NLEV;
		for (i = NLEV - 1; i >= 0; i--)
			if (queue_busy[i])
				lvl = i;
		if (lvl == NLEV) begin
			rec = '{EV_IDLE, 5'd0, 3'd0, 1'b1};
			expected_recs.insert(expected_recs.size(), rec);
			return;
		end
		dequeue(lvl, p);
		if (r.fin)
			rec = '{EV_EXITED, 5'(p) + 5'd1, 3'd0, 1'b0};
		else if (r.full) begin
			dst = (lvl + 1 < levels_in_use()) ? lvl + 1 : lvl;
			enqueue(dst, p);
			rec = '{EV_DEMOTED, 5'(p) + 5'd1, label_for(dst), 1'b0};
		end else begin
			enqueue(lvl, p);
			rec = '{EV_STAYED, 5'(p) + 5'd1, label_for(lvl), 1'b0};
		end
		recs.insert(recs.size(), rec);
		period = (cfg_period == 16'd0) ? 16'd1 : cfg_period;
		slice_tally = slice_tally + 16'd1;
		if (slice_tally >= period) begin
			slice_tally = '0;
			// walk lower queues high to low, each in arrival order
			for (i = 1; i < NLEV; i++)
				while (queue_busy[i]) begin
					dequeue(i, p);
					enqueue(0, p);
					rec = '{EV_BOOSTED, 5'(p) + 5'd1, levels_in_use(), 1'b0};
					recs.insert(recs.size(), rec);
				end
		end
		recs[recs.size() - 1].last = 1'b1;
		foreach (recs[k])
			expected_recs.insert(expected_recs.size(), recs[k]);
	endtask

	task automatic check_field(string name, logic [4:0] want, logic [4:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	initial begin
		forever #1 clk = ~clk;
	end

	// input driver: hold valid and payload until the transaction completes
	always @(posedge clk or negedge arst_n) begin
		sched_req_t req;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				schedule_item('{opcode, used_full_quantum, finishes});
				if (opcode == OP_START)
					n_starts++;
				else
					n_slices++;
			end
			if (!in_valid || in_ready) begin
				if (req_backlog.size() > 0 && (calm || $urandom_range(99) >= 35)) begin
					req = req_backlog.pop_front();
					in_valid <= 1'b1;
					opcode <= req.op;
					used_full_quantum <= req.full;
					finishes <= req.fin;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// register write driver
	always @(posedge clk or negedge arst_n) begin
		reg_write_t wr;
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PROCESS_COUNT: cfg_procs = cfg_data[4:0];
					CFG_LEVEL_COUNT:   cfg_levels = cfg_data[2:0];
					CFG_BOOST_PERIOD:  cfg_period = cfg_data;
					default: ;
				endcase
				n_writes++;
			end
			if (!cfg_valid || cfg_ready) begin
				if (cfg_backlog.size() > 0 && (calm || $urandom_range(99) >= 35)) begin
					wr = cfg_backlog.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= wr.idx;
					cfg_data <= wr.data;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		rec_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				n_results++;
				if (event_kind == EV_IDLE)
					n_idle++;
				if (event_kind == EV_BOOSTED)
					n_boosts++;
				if (expected_recs.size() == 0) begin
					errors++;
					$display({"%0t: unexpected record, expected none, ",
						"actual kind %0d id %0d label %0d last %0d"},
						$time, event_kind, process_id, queue_label, last);
				end else begin
					want = expected_recs.pop_front();
					check_field("event_kind", want.event_kind, event_kind);
					check_field("process_id", want.process_id, process_id);
					check_field("queue_label", want.queue_label, queue_label);
					check_field("last", want.last, last);
				end
			end
			out_ready <= calm || ($urandom_range(99) >= 35);
		end
	end

	// wait until nothing is in flight, then let a start walk finish
	task automatic settle();
		while (req_backlog.size() > 0 || in_valid || cfg_backlog.size() > 0 || cfg_valid
			|| expected_recs.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic program_regs(logic [4:0] pc, logic [2:0] lc, logic [15:0] bp, bit spare);
		reg_write_t wr;
		wr.idx = CFG_PROCESS_COUNT;
		wr.data = 16'($urandom);
		wr.data[4:0] = pc;
		cfg_backlog.insert(cfg_backlog.size(), wr);
		wr.idx = CFG_LEVEL_COUNT;
		wr.data = 16'($urandom);
		wr.data[2:0] = lc;
		cfg_backlog.insert(cfg_backlog.size(), wr);
		wr.idx = CFG_BOOST_PERIOD;
		wr.data = bp;
		cfg_backlog.insert(cfg_backlog.size(), wr);
		if (spare) begin
			wr.idx = CFG_SPARE_IDX;
			wr.data = 16'($urandom);
			cfg_backlog.insert(cfg_backlog.size(), wr);
		end
		n_settings++;
		settle();
	endtask

	task automatic queue_start();
		sched_req_t req;
		req = '{OP_START, 1'($urandom), 1'($urandom)};
		req_backlog.insert(req_backlog.size(), req);
	endtask

	task automatic queue_slice(logic full, logic fin);
		sched_req_t req;
		req = '{OP_SLICE, full, fin};
		req_backlog.insert(req_backlog.size(), req);
	endtask

	initial begin
		int phase, len, j, r, random_items;
		logic [4:0] pc;
		logic [2:0] lc;
		logic [15:0] bp;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: idle before any start, every slice outcome, one boost
		queue_slice(1'b0, 1'b0);
		queue_start();
		queue_slice(1'b1, 1'b0);
		queue_slice(1'b0, 1'b0);
		queue_slice(1'b0, 1'b1);
		queue_slice(1'b1, 1'b1);
		queue_slice(1'b1, 1'b0);
		queue_slice(1'b1, 1'b0);
		queue_slice(1'b0, 1'b0);
		queue_slice(1'b1, 1'b0);
		queue_slice(1'b1, 1'b0);
		settle();

		// one level, zero period: demote in place, then run dry
		program_regs(5'd1, 3'd1, 16'd0, 1'b0);
		queue_start();
		queue_slice(1'b1, 1'b0);
		queue_slice(1'b0, 1'b0);
		queue_slice(1'b0, 1'b1);
		queue_slice(1'b1, 1'b0);
		settle();

		// empty load with saturated level count
		program_regs(5'd0, 3'd7, 16'd1, 1'b1);
		queue_start();
		queue_slice(1'b1, 1'b0);
		settle();

		// two levels: saturate demotion at the bottom
		program_regs(5'd2, 3'd2, 16'hFFFF, 1'b0);
		queue_start();
		queue_slice(1'b1, 1'b0);
		queue_slice(1'b1, 1'b0);
		queue_slice(1'b1, 1'b0);
		queue_slice(1'b0, 1'b0);
		settle();

		// shrink level count under waiting processes, no restart
		program_regs(5'd2, 3'd1, 16'd2, 1'b0);
		queue_slice(1'b1, 1'b0);
		queue_slice(1'b0, 1'b0);
		queue_slice(1'b1, 1'b0);
		settle();

		random_items = 0;
		for (phase = 0; random_items < 380; phase++) begin
			r = $urandom_range(99);
			if (r < 5)
				pc = 5'd0;
			else if (r < 15)
				pc = 5'($urandom_range(31, 17));
			else if (r < 75)
				pc = 5'($urandom_range(8, 1));
			else
				pc = 5'($urandom_range(16, 1));
			lc = 3'($urandom_range(7));
			r = $urandom_range(99);
			if (r < 10)
				bp = 16'd0;
			else if (r < 20)
				bp = 16'($urandom);
			else
				bp = 16'($urandom_range(10, 1));
			if (phase == 0) begin
				pc = 5'd31;
				lc = 3'd0;
			end
			program_regs(pc, lc, bp, phase % 7 == 3);
			calm = (phase == 3 || phase == 4);
			if ($urandom_range(3) != 0) begin
				queue_start();
				random_items++;
			end
			len = calm ? 60 : $urandom_range(40, 15);
			for (j = 0; j < len; j++) begin
				// mostly slices, now and then a restart mid-run
				if ($urandom_range(99) < 4)
					queue_start();
				else
					queue_slice(1'($urandom), $urandom_range(99) < 18);
				random_items++;
			end
			settle();
		end
		calm = 1'b0;

		$display("covered %0d starts and %0d slices over %0d settings, %0d register writes",
			n_starts, n_slices, n_settings, n_writes);
		$display("checked %0d records: %0d idle, %0d boosted", n_results, n_idle, n_boosts);
		if (errors == 0)
			$display("tb_multilevel_feedback_queue_scheduler OK");
		else
			$display("tb_multilevel_feedback_queue_scheduler NOT OK");
		$finish;
	end

	initial begin
		#1000000;
		$display("timeout with %0d records outstanding", expected_recs.size());
		$display("tb_multilevel_feedback_queue_scheduler NOT OK");
		$finish;
	end

endmodule
